FILE: design/arms_pkg.sv
// Package for the audio RMS level meter.
// Holds fixed constants shared by the top level; no dependencies.
package arms_pkg;
    localparam int unsigned SampleW  = 16;
    localparam int unsigned CountW   = 12;
    localparam int unsigned LevelW   = 16;
    localparam int unsigned FracBits = 16;
    // 2560*log10(2) and 256*20*log10(65536/32767), both Q16
    localparam logic [25:0] LogMultQ16     = 26'd50504453;
    localparam logic [26:0] LevelOffsetQ16 = 27'd101013353;
endpackage

FILE: design/audio_rms_level_meter_top.sv
// Audio RMS level meter, top level.
// Depends on arms_pkg.
// Samples inside a block are taken one per cycle. The transfer that closes a block
// starts a sequencer around one shared 32x32 multiplier: N*sumsq (2 passes), sum^2,
// then two log2 runs (top-bit scan plus 16 squarings each) and a scale on a separate
// multiplier; a silent block skips them. tready is low from the closing transfer
// until tvalid rises, and longer if the previous result has not been taken. Reset
// (i_rst_n low, synchronous) clears accumulators, sequencer and the output valid.
module audio_rms_level_meter_top
    import arms_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] level_db, [27:16] block_count
    output logic        m_axis_tuser    // silent
);
    localparam int unsigned NW   = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SW   = SampleW + NW;          // signed sum
    localparam int unsigned QW   = 2 * SampleW - 1 + NW;  // square sum
    localparam int unsigned PW   = QW + NW;               // N*sumsq
    localparam int unsigned TW   = $clog2(PW + 1);
    localparam int unsigned KW   = $clog2(PW);            // scan / step counter

    typedef enum logic [3:0] {
        S_ACC, S_NQ0, S_NQ1, S_SS, S_SUB, S_SCAN, S_NORM, S_SQ, S_SQW,
        S_NEXT, S_MUL, S_OUT
    } t_state;

    t_state             r_state;
    logic signed [SW-1:0] r_sum;
    logic [QW-1:0]      r_sq;
    logic [NW-1:0]      r_cnt;
    logic [PW-1:0]      r_num;     // N*sumsq, then variance numerator
    logic [PW-1:0]      r_x;       // log2 operand
    logic [TW-1:0]      r_top;
    logic [32:0]        r_m;
    logic [KW-1:0]      r_k;
    logic               r_pass;    // 0: log2(num), 1: log2(N)
    logic [TW+FracBits-1:0] r_lnum;
    logic [FracBits-1:0] r_frac;
    logic signed [TW+FracBits+1:0] r_d;
    logic [63:0]        r_prod;
    logic [31:0]        r_ma, r_mb;
    logic               r_vld;
    logic [LevelW-1:0]  r_lvl;
    logic               r_sil;
    logic [CountW-1:0]  r_bc;
    logic [LevelW-1:0]  r_out_lvl;
    logic               r_out_sil;
    logic [CountW-1:0]  r_out_bc;

    // shared multiplier
    logic [63:0] w_mul;
    assign w_mul = {32'd0, r_ma} * {32'd0, r_mb};

    logic signed [SampleW-1:0] w_s;
    logic [SW-1:0] w_mag;
    logic [2*SampleW-1:0] w_sq;
    assign w_s   = s_axis_tdata;
    assign w_sq  = 32'(w_s * w_s);
    assign w_mag = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);

    // a waiting result sits in the output register; the next block may accumulate
    assign s_axis_tready = (r_state == S_ACC);
    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = {4'd0, r_out_bc, r_out_lvl};
    assign m_axis_tuser  = r_out_sil;

    logic w_done;
    logic [NW-1:0] w_cnt1;
    assign w_cnt1 = r_cnt + 1'b1;
    assign w_done = s_axis_tlast || (32'(w_cnt1) >= MAX_SAMPLES);

    logic [32:0] w_sqr;
    assign w_sqr = 33'(w_mul >> 31);

    logic signed [63:0] w_t;
    logic [63:0] w_u;
    logic signed [31:0] w_lvl;
    assign w_t   = $signed(r_prod) + $signed({37'd0, LevelOffsetQ16} << 16);
    assign w_u   = 64'(w_t + (64'sd1 <<< 50)) + (64'd1 << 31);
    assign w_lvl = 32'(w_u >> 32) - 32'sd262144;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_sum   <= '0;
            r_sq    <= '0;
            r_cnt   <= '0;
            r_vld   <= 1'b0;
        end else begin
            if (r_vld && m_axis_tready) r_vld <= 1'b0;
            unique case (r_state)
                S_ACC: if (s_axis_tvalid && s_axis_tready) begin
                    r_sum <= r_sum + SW'(w_s);
                    r_sq  <= r_sq + QW'(w_sq);
                    r_cnt <= w_cnt1;
                    if (w_done) begin
                        r_state <= S_NQ0;
                        r_ma <= 32'(w_cnt1);
                        r_mb <= 32'(r_sq + QW'(w_sq));
                    end
                end
                S_NQ0: begin
                    r_sum <= r_sum;
                    r_num <= PW'(w_mul);
                    r_ma  <= 32'(r_cnt);
                    r_mb  <= 32'((r_sq) >> 32);
                    r_state <= S_NQ1;
                end
                S_NQ1: begin
                    r_num <= r_num + PW'({w_mul, 32'd0});
                    r_ma  <= 32'(w_mag);
                    r_mb  <= 32'(w_mag);
                    r_state <= S_SS;
                end
                S_SS: begin
                    r_num <= r_num - PW'(w_mul);
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_bc <= CountW'(r_cnt);
                    if (r_num == '0) begin
                        r_lvl <= 16'h8000;
                        r_sil <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_x <= r_num;
                        r_pass <= 1'b0;
                        r_top <= '0;
                        r_k <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // one bit per cycle top-bit search
                    if (r_x[r_k]) r_top <= TW'(r_k);
                    if (32'(r_k) == PW - 1) r_state <= S_NORM;
                    r_k <= r_k + 1'b1;
                end
                S_NORM: begin
                    if (32'(r_top) >= 31) r_m <= 33'(r_x >> (r_top - TW'(31)));
                    else r_m <= 33'(r_x << (TW'(31) - r_top));
                    r_frac <= '0;
                    r_k <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_ma <= r_m[31:0];
                    r_mb <= r_m[31:0];
                    r_state <= S_SQW;
                end
                S_SQW: begin
                    r_frac <= {r_frac[FracBits-2:0], w_sqr[32]};
                    r_m <= w_sqr[32] ? (w_sqr >> 1) : w_sqr;
                    r_k <= r_k + 1'b1;
                    r_state <= (r_k == KW'(15)) ? S_NEXT : S_SQ;
                end
                S_NEXT: begin
                    if (!r_pass) begin
                        r_lnum <= {r_top, r_frac};
                        r_x <= PW'(r_cnt);
                        r_pass <= 1'b1;
                        r_top <= '0;
                        r_k <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_d <= $signed({2'b0, r_lnum})
                             - $signed({1'b0, r_top, r_frac, 1'b0});
                        r_state <= S_MUL;
                        r_k <= '0;
                    end
                end
                S_MUL: begin
                    r_prod <= 64'($signed(r_d) * $signed({1'b0, LogMultQ16}));
                    r_k <= r_k + 1'b1;
                    if (r_k == KW'(1)) begin
                        r_sil <= 1'b0;
                        if (w_lvl > 32767) r_lvl <= 16'h7FFF;
                        else if (w_lvl < -32768) r_lvl <= 16'h8000;
                        else r_lvl <= w_lvl[15:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (!r_vld) begin
                    r_vld <= 1'b1;
                    r_out_lvl <= r_lvl;
                    r_out_sil <= r_sil;
                    r_out_bc  <= r_bc;
                    r_sum <= '0;
                    r_sq  <= '0;
                    r_cnt <= '0;
                    r_state <= S_ACC;
                end
                default: r_state <= S_ACC;
            endcase
        end
    end
endmodule

FILE: verif/tb.sv
// Testbench for audio_rms_level_meter_top: sample stream in, one level per block out.
// Depends on arms_pkg and the top level; predicts each level with its own integer model.
module tb;
    import arms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] level;
        logic               silent;
        logic [11:0]        count;
    } level_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] sample
    logic        s_axis_tlast;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [15:0] level_db, [27:16] block_count
    logic        m_axis_tuser;   // silent

    audio_rms_level_meter_top i_dut (.*);

    level_t      level_q[$];
    longint      acc_sum;
    logic [63:0] acc_sq;
    int unsigned acc_n;
    int unsigned n_samples, n_levels, n_silent, n_errors;
    int unsigned hold_cycles;
    bit          no_idle;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("** audio_rms_level_meter_top: FAILED **");
        $finish;
    end

    function automatic logic [63:0] log2_fixed(logic [63:0] x);
        int unsigned top;
        logic [63:0] m;
        logic [63:0] frac;
        top = 0;
        frac = '0;
        for (int k = 0; k < 64; k++)
            if (x[k]) top = k;
        m = (top >= 31) ? (x >> (top - 31)) : (x << (31 - top));
        m &= 64'hFFFF_FFFF;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac |= 64'd1;
                m = m >> 1;
            end
        end
        return (64'(top) << 16) | frac;
    endfunction

    // fold one accepted sample into the accumulators; queue a level at block end
    function automatic void accumulate(logic signed [15:0] smp, logic lst);
        logic [63:0] mag, num, u;
        longint      d, t, lv;
        level_t      r;
        acc_sum += longint'(smp);
        acc_sq  += 64'(longint'(smp) * longint'(smp));
        acc_n++;
        if (!lst && acc_n < 2048) return;
        mag = 64'(acc_sum < 0 ? -acc_sum : acc_sum);
        num = 64'(acc_n) * acc_sq - mag * mag;
        r.count = acc_n[11:0];
        if (num == 0) begin
            r.silent = 1'b1;
            r.level  = 16'sh8000;
        end else begin
            d  = longint'(log2_fixed(num)) - 2 * longint'(log2_fixed(64'(acc_n)));
            t  = d * longint'(LogMultQ16) + longint'(LevelOffsetQ16) * 65536;
            u  = 64'(t) + (64'd1 << 50) + (64'd1 << 31);
            lv = longint'(u >> 32) - (64'sd1 <<< 18);
            if (lv > 32767) lv = 32767;
            if (lv < -32768) lv = -32768;
            r.silent = 1'b0;
            r.level  = lv[15:0];
        end
        level_q.push_back(r);
        acc_sum = 0;
        acc_sq  = '0;
        acc_n   = 0;
    endfunction

    task automatic send_sample(logic signed [15:0] smp, logic lst);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        accumulate(smp, lst);
        n_samples++;
    endtask

    task automatic send_block(int unsigned len, int unsigned kind);
        logic signed [15:0] smp, base;
        base = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            case (kind)
                0: smp = 16'($urandom);
                1: smp = base + $signed(16'($urandom_range(15))) - 16'sd8;
                2: smp = base;
                default: smp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            endcase
            send_sample(smp, i == len - 1);
        end
    endtask

    // result side: random stalls, an optional long hold-off, field checks
    initial begin
        int unsigned gap;
        level_t exp_r;
        forever begin
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            gap = no_idle ? 0 : $urandom_range(8);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            n_levels++;
            if (level_q.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b", $time,
                         m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                exp_r = level_q.pop_front();
                if (exp_r.silent) n_silent++;
                if (m_axis_tdata[15:0] !== exp_r.level) begin
                    $display("%0t: level_db expected %0d actual %0d", $time,
                             exp_r.level, $signed(m_axis_tdata[15:0]));
                    n_errors++;
                end
                if (m_axis_tuser !== exp_r.silent) begin
                    $display("%0t: silent expected %b actual %b", $time,
                             exp_r.silent, m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tdata[27:16] !== exp_r.count) begin
                    $display("%0t: block_count expected %0d actual %0d", $time,
                             exp_r.count, m_axis_tdata[27:16]);
                    n_errors++;
                end
                if (m_axis_tdata[31:28] !== 4'd0) begin
                    $display("%0t: tdata pad expected 0 actual %h", $time,
                             m_axis_tdata[31:28]);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_edge_cases();
        send_sample(16'sd1234, 1'b1);                 // one sample: silent
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);                 // full-scale swing
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b1);                    // zero block
        repeat (3) send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b1);                 // constant at min
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd1, 1'b1);                    // smallest variance
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shAAAA, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFE, 1'b1);
    endtask

    task automatic test_random_blocks();
        int unsigned len, start;
        start = n_samples;
        while (n_samples - start < 1350) begin
            no_idle = ($urandom_range(9) == 0);
            len = ($urandom_range(9) == 0) ? $urandom_range(300, 17) : $urandom_range(16, 1);
            send_block(len, $urandom_range(3));
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while short blocks keep coming, so input backs up
    task automatic test_backpressure();
        hold_cycles = 900;
        no_idle = 1'b1;
        repeat (8) send_block($urandom_range(4, 1), 0);
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        acc_sum = 0;
        acc_sq  = '0;
        acc_n   = 0;
        n_samples = 0; n_levels = 0; n_silent = 0; n_errors = 0;
        hold_cycles = 0;
        no_idle = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_cases();
        test_backpressure();
        test_random_blocks();
        test_backpressure();

        s_axis_tvalid <= 1'b0;
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Covered %0d samples in %0d blocks (%0d silent), edge levels and",
                 n_samples, n_levels, n_silent);
        $display("long output stalls that back up the input; %0d mismatches.", n_errors);
        if (n_errors == 0)
            $display("** audio_rms_level_meter_top: PASSED **");
        else
            $display("** audio_rms_level_meter_top: FAILED **");
        $finish;
    end
endmodule
